[hdl/cdts_pkg.sv]
// Shared opcodes, status codes and field widths for the connection deadline timer set.
package cdts_pkg;

  localparam int SlotCount = 3;
  localparam int UserSlot  = 2;

  typedef logic [2:0]  opcode_t;
  typedef logic [1:0]  status_t;
  typedef logic [1:0]  fired_t;
  typedef logic [31:0] tick_t;
  typedef logic [30:0] msec_t;

  localparam opcode_t OP_ARM_DELAY    = 3'd0;
  localparam opcode_t OP_CANCEL_DELAY = 3'd1;
  localparam opcode_t OP_SET_USER     = 3'd2;
  localparam opcode_t OP_ADD_USER     = 3'd3;
  localparam opcode_t OP_MIN_USER     = 3'd4;
  localparam opcode_t OP_MAX_USER     = 3'd5;
  localparam opcode_t OP_CANCEL_USER  = 3'd6;
  localparam opcode_t OP_POP          = 3'd7;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_UNCHANGED = 2'd1;
  localparam status_t ST_INVALID   = 2'd2;

  localparam fired_t FIRED_NONE  = 2'd0;
  localparam fired_t FIRED_READ  = 2'd1;
  localparam fired_t FIRED_WRITE = 2'd2;
  localparam fired_t FIRED_USER  = 2'd3;

endpackage

[hdl/connection_deadline_timer_set.sv]
// Top level: three wrap-around deadline timers run by a sequencer around one shared adder.
//
// Each transfer is accepted in idle and then steps through an opcode step, a check
// step for min and max, a pop step per slot examined (stopping at the first expired
// slot), a scan step per slot and a finish step. All arithmetic goes through a single
// 32-bit adder/subtractor: the opcode step applies the opcode, the scan steps find the
// earliest armed deadline, and the finish step forms the remaining time. A finished
// result sits in the output register while the next transfer is taken.
module connection_deadline_timer_set (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // msec[30:0], now[62:31], zero[63]
  input  logic [3:0]  s_tuser,   // opcode[2:0], slot[3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], fired[3:2], any_armed[4],
                                 // timeout_ms[35:5], armed_mask[38:36], zero[39]
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [1:0] LastIdx = 2'(cdts_pkg::SlotCount - 1);
  localparam logic [1:0] UserIdx = 2'(cdts_pkg::UserSlot);

  logic [2:0]           state;
  cdts_pkg::opcode_t    opcode;
  logic                 slot;
  cdts_pkg::msec_t      msec;
  cdts_pkg::tick_t      now;
  cdts_pkg::tick_t      dl [cdts_pkg::SlotCount];
  logic [2:0]           armed;
  logic [1:0]           idx;
  logic                 have;
  cdts_pkg::tick_t      earliest;
  cdts_pkg::tick_t      diff;
  cdts_pkg::status_t    status;
  cdts_pkg::fired_t     fired;

  cdts_pkg::tick_t      alu_a;
  cdts_pkg::tick_t      alu_b;
  logic                 alu_sub;
  cdts_pkg::tick_t      alu_res;
  cdts_pkg::tick_t      user_val;
  logic                 declined;
  logic                 out_free;
  cdts_pkg::msec_t      timeout;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    alu_a   = now;
    alu_b   = {1'b0, msec};
    alu_sub = 1'b0;
    case (state)
      S_OP: begin
        if (opcode == cdts_pkg::OP_ADD_USER) begin
          alu_a = dl[UserIdx];
        end else if (opcode == cdts_pkg::OP_MIN_USER || opcode == cdts_pkg::OP_MAX_USER) begin
          alu_a   = dl[UserIdx];
          alu_b   = now;
          alu_sub = 1'b1;
        end
      end
      S_POP: begin
        alu_a   = dl[idx];
        alu_b   = now;
        alu_sub = 1'b1;
      end
      S_SCAN: begin
        alu_a   = dl[idx];
        alu_b   = earliest;
        alu_sub = 1'b1;
      end
      S_FIN: begin
        alu_a   = earliest;
        alu_b   = now;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_res  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    user_val = (alu_res == '0) ? 32'd1 : alu_res;
    timeout  = (have && !alu_res[31]) ? alu_res[30:0] : '0;
  end

  always_comb begin
    if (opcode == cdts_pkg::OP_MIN_USER) begin
      declined = armed[UserIdx] && (diff[31] || diff[30:0] <= msec);
    end else begin
      declined = armed[UserIdx] && !diff[31] && (diff[30:0] >= msec);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      armed    <= '0;
      dl       <= '{default: '0};
      m_tvalid <= 1'b0;
      idx      <= '0;
      have     <= 1'b0;
      status   <= cdts_pkg::ST_DONE;
      fired    <= cdts_pkg::FIRED_NONE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            opcode <= s_tuser[2:0];
            slot   <= s_tuser[3];
            msec   <= s_tdata[30:0];
            now    <= s_tdata[62:31];
            status <= cdts_pkg::ST_DONE;
            fired  <= cdts_pkg::FIRED_NONE;
            idx    <= '0;
            have   <= 1'b0;
            state  <= S_OP;
          end
        end
        S_OP: begin
          case (opcode)
            cdts_pkg::OP_ARM_DELAY: begin
              dl[{1'b0, slot}]    <= alu_res;
              armed[{1'b0, slot}] <= 1'b1;
              state               <= S_SCAN;
            end
            cdts_pkg::OP_CANCEL_DELAY: begin
              armed[{1'b0, slot}] <= 1'b0;
              state               <= S_SCAN;
            end
            cdts_pkg::OP_SET_USER, cdts_pkg::OP_ADD_USER: begin
              dl[UserIdx]    <= user_val;
              armed[UserIdx] <= 1'b1;
              state          <= S_SCAN;
            end
            cdts_pkg::OP_MIN_USER, cdts_pkg::OP_MAX_USER: begin
              diff  <= alu_res;
              state <= S_CHK;
            end
            cdts_pkg::OP_CANCEL_USER: begin
              if (armed[UserIdx]) begin
                armed[UserIdx] <= 1'b0;
                dl[UserIdx]    <= '0;
              end
              state <= S_SCAN;
            end
            default: begin
              state <= S_POP;
            end
          endcase
        end
        S_CHK: begin
          if (declined) begin
            status <= cdts_pkg::ST_UNCHANGED;
          end else begin
            dl[UserIdx]    <= user_val;
            armed[UserIdx] <= 1'b1;
          end
          state <= S_SCAN;
        end
        S_POP: begin
          if (armed[idx] && (alu_res[31] || alu_res == '0)) begin
            armed[idx] <= 1'b0;
            case (idx)
              2'd0:    fired <= cdts_pkg::FIRED_READ;
              2'd1:    fired <= cdts_pkg::FIRED_WRITE;
              default: fired <= cdts_pkg::FIRED_USER;
            endcase
            idx   <= '0;
            state <= S_SCAN;
          end else if (idx == LastIdx) begin
            idx   <= '0;
            state <= S_SCAN;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_SCAN: begin
          if (armed[idx] && (!have || alu_res[31])) begin
            earliest <= dl[idx];
            have     <= 1'b1;
          end
          if (idx == LastIdx) begin
            state <= S_FIN;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, armed, timeout, (armed != '0), fired, status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (m_tvalid && m_tready && !(state == S_FIN)) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[hdl/cdts_checker.sv]
// Port-level checks for the connection deadline timer set, bound to the top level.
module cdts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  ap_any_armed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4] == (m_tdata[38:36] != 3'd0)))
    else $error("any_armed disagrees with armed_mask");

  ap_no_invalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != cdts_pkg::ST_INVALID))
    else $error("invalid status reported");

  ap_idle_timeout: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[38:36] == 3'd0) |-> (m_tdata[35:5] == '0))
    else $error("nonzero timeout with nothing armed");

  ap_fired_disarmed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[3:2] != cdts_pkg::FIRED_READ  || !m_tdata[36]) &&
                  (m_tdata[3:2] != cdts_pkg::FIRED_WRITE || !m_tdata[37]) &&
                  (m_tdata[3:2] != cdts_pkg::FIRED_USER  || !m_tdata[38])))
    else $error("fired slot still armed");

  ap_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result dropped or changed while stalled");

endmodule

bind connection_deadline_timer_set cdts_checker u_cdts_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[dv/tb_connection_deadline_timer_set.sv]
// Self-checking testbench for the connection deadline timer set stream block.
module tb_connection_deadline_timer_set;

  typedef struct packed {
    cdts_pkg::opcode_t op;
    logic              slot;
    cdts_pkg::msec_t   msec;
    cdts_pkg::tick_t   now;
    logic              drain;
  } timer_req_t;

  typedef struct packed {
    logic [2:0]        mask;
    cdts_pkg::msec_t   timeout;
    logic              any;
    cdts_pkg::fired_t  fired;
    cdts_pkg::status_t status;
  } timer_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;  // msec[30:0], now[62:31], zero[63]
  logic [3:0]  s_tuser = '0;  // opcode[2:0], slot[3]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // status[1:0], fired[3:2], any_armed[4],
                              // timeout_ms[35:5], armed_mask[38:36], zero[39]

  timer_req_t      req_q[$];
  timer_resp_t     resp_q[$];
  timer_req_t      in_flight;
  cdts_pkg::tick_t deadline_q[cdts_pkg::SlotCount] = '{default: '0};
  logic [2:0]      armed_q = '0;
  int              n_total = 0;
  int              n_accepted = 0;
  int              n_checked = 0;
  int              errors = 0;

  connection_deadline_timer_set dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [31:0] span(cdts_pkg::tick_t a, cdts_pkg::tick_t b);
    return $signed(a - b);
  endfunction

  function automatic int unsigned idle_pct(bit sender);
    int phase;
    phase = (n_accepted * 3) / n_total;
    case (phase)
      0: return sender ? 24 : 54;
      1: return sender ? 54 : 24;
      default: return 0;
    endcase
  endfunction

  function automatic void load_user(cdts_pkg::tick_t value);
    deadline_q[cdts_pkg::UserSlot] = (value == '0) ? 32'd1 : value;
    armed_q[cdts_pkg::UserSlot] = 1'b1;
  endfunction

  function automatic timer_resp_t timer_update(timer_req_t req);
    timer_resp_t        res;
    cdts_pkg::tick_t    fresh;
    cdts_pkg::tick_t    earliest;
    logic               have;
    logic signed [31:0] left;
    res = '0;
    earliest = '0;
    have = 1'b0;
    fresh = req.now + {1'b0, req.msec};
    case (req.op)
      cdts_pkg::OP_ARM_DELAY: begin
        deadline_q[req.slot] = fresh;
        armed_q[req.slot] = 1'b1;
      end
      cdts_pkg::OP_CANCEL_DELAY: armed_q[req.slot] = 1'b0;
      cdts_pkg::OP_SET_USER: load_user(fresh);
      cdts_pkg::OP_ADD_USER: load_user(deadline_q[cdts_pkg::UserSlot] + {1'b0, req.msec});
      cdts_pkg::OP_MIN_USER: begin
        if (armed_q[cdts_pkg::UserSlot] &&
            span(deadline_q[cdts_pkg::UserSlot], req.now) <= $signed({1'b0, req.msec})) begin
          res.status = cdts_pkg::ST_UNCHANGED;
        end else begin
          load_user(fresh);
        end
      end
      cdts_pkg::OP_MAX_USER: begin
        if (armed_q[cdts_pkg::UserSlot] &&
            span(deadline_q[cdts_pkg::UserSlot], req.now) >= $signed({1'b0, req.msec})) begin
          res.status = cdts_pkg::ST_UNCHANGED;
        end else begin
          load_user(fresh);
        end
      end
      cdts_pkg::OP_CANCEL_USER: begin
        if (armed_q[cdts_pkg::UserSlot]) begin
          armed_q[cdts_pkg::UserSlot] = 1'b0;
          deadline_q[cdts_pkg::UserSlot] = '0;
        end
      end
      default: begin
        for (int n = 0; n < cdts_pkg::SlotCount; n++) begin
          if (!have && armed_q[n] && span(deadline_q[n], req.now) <= 0) begin
            armed_q[n] = 1'b0;
            have = 1'b1;
            res.fired = (n == cdts_pkg::UserSlot) ? cdts_pkg::FIRED_USER :
                        (n == 0) ? cdts_pkg::FIRED_READ : cdts_pkg::FIRED_WRITE;
          end
        end
        have = 1'b0;
      end
    endcase
    for (int n = 0; n < cdts_pkg::SlotCount; n++) begin
      if (armed_q[n]) begin
        if (!have || span(deadline_q[n], earliest) < 0) earliest = deadline_q[n];
        have = 1'b1;
      end
    end
    if (have) begin
      left = span(earliest, req.now);
      res.timeout = (left < 0) ? '0 : left[30:0];
    end
    res.any = |armed_q;
    res.mask = armed_q;
    return res;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic queue_req(cdts_pkg::opcode_t op, logic slot, cdts_pkg::msec_t msec,
                           cdts_pkg::tick_t now, logic drain);
    timer_req_t req;
    req.op = op;
    req.slot = slot;
    req.msec = msec;
    req.now = now;
    req.drain = drain;
    req_q.push_back(req);
  endtask

  always @(posedge clk) begin : drive_proc
    logic took;
    took = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (took) begin
        resp_q.push_back(timer_update(in_flight));
        n_accepted <= n_accepted + 1;
      end
      if (!s_tvalid || took) begin
        if (req_q.size() != 0 &&
            !(req_q[0].drain && (took || n_accepted != n_checked)) &&
            $urandom_range(99) >= idle_pct(1'b1)) begin
          in_flight = req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {1'b0, in_flight.now, in_flight.msec};
          s_tuser <= {in_flight.slot, in_flight.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_proc
    timer_resp_t want;
    timer_resp_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= idle_pct(1'b0));
      if (m_tvalid && m_tready) begin
        got = m_tdata[38:0];
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = resp_q.pop_front();
          n_checked <= n_checked + 1;
          check_field("status", want.status, got.status);
          check_field("fired", want.fired, got.fired);
          check_field("any_armed", want.any, got.any);
          check_field("timeout_ms", want.timeout, got.timeout);
          check_field("armed_mask", want.mask, got.mask);
        end
      end
    end
  end

  initial begin
    cdts_pkg::tick_t tick;
    int              pick;
    cdts_pkg::msec_t dur;
    // directed: empty timers, zero fix, min/max both ways, wrap and clamp
    queue_req(cdts_pkg::OP_POP, 1'b0, '0, '0, 1'b0);
    queue_req(cdts_pkg::OP_CANCEL_DELAY, 1'b1, '0, 32'hFFFF_FFFF, 1'b0);
    queue_req(cdts_pkg::OP_CANCEL_USER, 1'b0, '0, '0, 1'b0);
    queue_req(cdts_pkg::OP_ADD_USER, 1'b0, '0, '0, 1'b0);
    queue_req(cdts_pkg::OP_SET_USER, 1'b0, 31'd5, 32'hFFFF_FFFB, 1'b0);
    queue_req(cdts_pkg::OP_ARM_DELAY, 1'b0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(cdts_pkg::OP_ARM_DELAY, 1'b1, '0, 32'd100, 1'b0);
    queue_req(cdts_pkg::OP_MIN_USER, 1'b0, 31'd10, '0, 1'b0);
    queue_req(cdts_pkg::OP_MIN_USER, 1'b0, '0, '0, 1'b0);
    queue_req(cdts_pkg::OP_MAX_USER, 1'b0, '0, '0, 1'b0);
    queue_req(cdts_pkg::OP_MAX_USER, 1'b0, 31'd1000, '0, 1'b0);
    queue_req(cdts_pkg::OP_ADD_USER, 1'b0, 31'h7FFF_FFFF, '0, 1'b0);
    queue_req(cdts_pkg::OP_POP, 1'b0, '0, 32'd50, 1'b0);
    queue_req(cdts_pkg::OP_POP, 1'b1, '0, 32'd100, 1'b1);
    queue_req(cdts_pkg::OP_POP, 1'b0, '0, 32'h8000_0000, 1'b0);
    queue_req(cdts_pkg::OP_POP, 1'b0, '0, 32'h8000_0000, 1'b0);
    queue_req(cdts_pkg::OP_POP, 1'b0, '0, 32'hFFFF_FFFF, 1'b0);
    queue_req(cdts_pkg::OP_CANCEL_USER, 1'b0, '0, 32'hFFFF_FFFF, 1'b0);
    queue_req(cdts_pkg::OP_ARM_DELAY, 1'b0, '0, 32'h1234_5678, 1'b0);
    queue_req(cdts_pkg::OP_ARM_DELAY, 1'b1, 31'd10, 32'h1234_5678, 1'b0);
    queue_req(cdts_pkg::OP_SET_USER, 1'b0, 31'd20, 32'h1234_5678, 1'b0);
    queue_req(cdts_pkg::OP_POP, 1'b0, '0, 32'h1234_5690, 1'b0);
    queue_req(cdts_pkg::OP_CANCEL_DELAY, 1'b1, '0, 32'h1234_5690, 1'b0);
    queue_req(cdts_pkg::OP_CANCEL_USER, 1'b0, '0, 32'h1234_5690, 1'b0);
    queue_req(cdts_pkg::OP_CANCEL_DELAY, 1'b0, 31'h7FFF_FFFF, 32'h1234_5690, 1'b0);
    tick = $urandom();
    for (int i = 0; i < 1550; i++) begin
      if ($urandom_range(99) < 4) tick = $urandom();
      else tick = tick + $urandom_range(0, 300);
      case ($urandom_range(9))
        0: dur = '0;
        1: dur = 31'h7FFF_FFFF;
        2: dur = cdts_pkg::msec_t'($urandom());
        default: dur = cdts_pkg::msec_t'($urandom_range(0, 1500));
      endcase
      pick = $urandom_range(10);
      queue_req((pick > 7) ? cdts_pkg::OP_POP : cdts_pkg::opcode_t'(pick),
                1'($urandom_range(1)), dur, tick, $urandom_range(199) == 0);
    end
    n_total = req_q.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (n_checked != n_total) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
